### hdl/eipd_pkg.sv
// Package for the extended instruction pair decoder.
// Holds the bank offset, the group, sub-op, mnemonic, operand-form and handler codes,
// and the register-bank helper. It depends on nothing.
`default_nettype none

package eipd_pkg;

	// Offset added to a register nibble when its bank bit is set.
	localparam logic [4:0] HIGH_BANK_OFFSET = 5'd16;

	// Groups, taken from the top nibble of the main word.
	localparam logic [3:0] GRP_IDX_MEM  = 4'h0;
	localparam logic [3:0] GRP_ST_D4    = 4'h1;
	localparam logic [3:0] GRP_ST_DISP  = 4'h2;
	localparam logic [3:0] GRP_CMP_ALU  = 4'h3;
	localparam logic [3:0] GRP_SHIFT    = 4'h4;
	localparam logic [3:0] GRP_LD_D4    = 4'h5;
	localparam logic [3:0] GRP_LD_DISP  = 4'h6;
	localparam logic [3:0] GRP_ADD_IMM  = 4'h7;
	localparam logic [3:0] GRP_MOV_IMM  = 4'hE;

	// Sub-op codes, taken from the low nibble of the main word.
	localparam logic [3:0] SUB_FST      = 4'h4;
	localparam logic [3:0] SUB_FLD      = 4'h6;
	localparam logic [3:0] SUB_AND      = 4'h9;
	localparam logic [3:0] SUB_XOR      = 4'hA;
	localparam logic [3:0] SUB_OR       = 4'hB;
	localparam logic [3:0] SUB_MUL      = 4'hE;
	localparam logic [3:0] SUB_MUL_NEG  = 4'hF;
	localparam logic [3:0] SUB_CMP_EQ   = 4'h0;
	localparam logic [3:0] SUB_CMP_HS   = 4'h2;
	localparam logic [3:0] SUB_CMP_GE   = 4'h3;
	localparam logic [3:0] SUB_CMP_HI   = 4'h6;
	localparam logic [3:0] SUB_CMP_GT   = 4'h7;
	localparam logic [3:0] SUB_ALU_SUB  = 4'h8;
	localparam logic [3:0] SUB_ALU_AND  = 4'h9;
	localparam logic [3:0] SUB_ALU_ADD  = 4'hC;
	localparam logic [3:0] SUB_SHAD     = 4'hC;
	localparam logic [3:0] SUB_SHLD     = 4'hD;
	localparam logic [3:0] SUB_NONE     = 4'hF;

	// Mnemonic codes.
	localparam logic [4:0] MN_MOVB  = 5'd0;
	localparam logic [4:0] MN_MOVL  = 5'd2;
	localparam logic [4:0] MN_MOVQ  = 5'd3;
	localparam logic [4:0] MN_MOVUB = 5'd4;
	localparam logic [4:0] MN_FMOVS = 5'd7;
	localparam logic [4:0] MN_AND   = 5'd8;
	localparam logic [4:0] MN_XOR   = 5'd9;
	localparam logic [4:0] MN_OR    = 5'd10;
	localparam logic [4:0] MN_MULL  = 5'd11;
	localparam logic [4:0] MN_CMPEQ = 5'd12;
	localparam logic [4:0] MN_SUB   = 5'd22;
	localparam logic [4:0] MN_ADD   = 5'd23;
	localparam logic [4:0] MN_SHAD  = 5'd24;
	localparam logic [4:0] MN_SHLD  = 5'd25;
	localparam logic [4:0] MN_LEAB  = 5'd26;
	localparam logic [4:0] MN_MOV   = 5'd30;

	// Operand forms.
	localparam logic [2:0] FORM_ST_IDX  = 3'd0;
	localparam logic [2:0] FORM_LD_IDX  = 3'd1;
	localparam logic [2:0] FORM_ST_DISP = 3'd2;
	localparam logic [2:0] FORM_LD_DISP = 3'd3;
	localparam logic [2:0] FORM_RIR     = 3'd4;
	localparam logic [2:0] FORM_RI      = 3'd5;

	// Handler codes.
	localparam logic [5:0] HD_ST_IDX_B  = 6'd0;
	localparam logic [5:0] HD_ST_IDX_L  = 6'd2;
	localparam logic [5:0] HD_ST_IDX_Q  = 6'd3;
	localparam logic [5:0] HD_LD_IDX_B  = 6'd4;
	localparam logic [5:0] HD_LD_IDX_L  = 6'd8;
	localparam logic [5:0] HD_LD_IDX_Q  = 6'd10;
	localparam logic [5:0] HD_ST_DISP_B = 6'd11;
	localparam logic [5:0] HD_FST_DISP  = 6'd15;
	localparam logic [5:0] HD_FLD_DISP  = 6'd16;
	localparam logic [5:0] HD_AND_RIR   = 6'd17;
	localparam logic [5:0] HD_XOR_RIR   = 6'd18;
	localparam logic [5:0] HD_OR_RIR    = 6'd19;
	localparam logic [5:0] HD_MUL_RIR   = 6'd20;
	localparam logic [5:0] HD_CMP_EQ    = 6'd21;
	localparam logic [5:0] HD_SUB_RIR   = 6'd31;
	localparam logic [5:0] HD_ADD_RIR   = 6'd32;
	localparam logic [5:0] HD_SHAD      = 6'd33;
	localparam logic [5:0] HD_SHLD      = 6'd34;
	localparam logic [5:0] HD_LD_DISP_B = 6'd35;
	localparam logic [5:0] HD_LEA_DISP  = 6'd39;
	localparam logic [5:0] HD_LDU_DISP  = 6'd40;
	localparam logic [5:0] HD_ADD_RI    = 6'd43;
	localparam logic [5:0] HD_MOV_RI    = 6'd44;
	localparam logic [5:0] HD_MAX       = 6'd44;

	// Register number of a nibble, moved to the high bank when its bank bit is set.
	function automatic logic [4:0] bank_reg(input logic [3:0] nib, input logic hi);
		return hi ? (5'(nib) + HIGH_BANK_OFFSET) : 5'(nib);
	endfunction

endpackage

`default_nettype wire

### hdl/extended_instruction_pair_decoder.sv
// Top level of the extended instruction pair decoder.
// Registers a prefix/main word pair, decodes it, and registers the result.
// Depends on eipd_pkg.
`default_nettype none

// The decoder takes one instruction pair per clock: busy is always low, so a
// request is taken at every edge where start is high. Each request gives one
// result, shown for one cycle with done high; the path is an input register,
// one level of decode logic and a result register. Results come in request
// order and the receiver cannot stall them, so it must take each one in the
// cycle done is high. Between results the output ports hold the last result.
module extended_instruction_pair_decoder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [15:0]         prefix_word,
	input  wire logic [15:0]         main_word,
	output logic                     done,
	output logic                     decoded,
	output logic [4:0]               mnemonic,
	output logic [2:0]               operand_form,
	output logic [5:0]               handler,
	output logic [4:0]               dest_reg,
	output logic [4:0]               src_reg,
	output logic [4:0]               index_reg,
	output logic signed [13:0]       immediate
);
	import eipd_pkg::*;

	logic        valid_s1;
	logic [15:0] prefix_s1;
	logic [15:0] main_s1;

	logic        dec_c;
	logic [4:0]  mn_c;
	logic [2:0]  fm_c;
	logic [5:0]  hd_c;
	logic [4:0]  rd_c;
	logic [4:0]  rs_c;
	logic [4:0]  rx_c;
	logic [13:0] imm_c;

	logic [3:0]  grp;
	logic [3:0]  sub;
	logic [3:0]  n1;
	logic [3:0]  n2;
	logic [1:0]  s;
	logic [2:0]  k;
	logic [4:0]  rx_idx;

	// The decoder never holds off a request.
	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prefix_s1 <= prefix_word;
			main_s1   <= main_word;
		end
	end

	// Fields of the main word.
	assign grp    = main_s1[15:12];
	assign n1     = main_s1[11:8];
	assign n2     = main_s1[7:4];
	assign sub    = main_s1[3:0];
	assign s      = main_s1[1:0];
	assign rx_idx = bank_reg(prefix_s1[3:0], prefix_s1[4]);

	// Compare sub-op to its dense index.
	always_comb begin
		case (sub)
			SUB_CMP_EQ: k = 3'd0;
			SUB_CMP_HS: k = 3'd1;
			SUB_CMP_GE: k = 3'd2;
			SUB_CMP_HI: k = 3'd3;
			SUB_CMP_GT: k = 3'd4;
			default:    k = 3'd0;
		endcase
	end

	// Decode of one pair; fields a case does not set stay zero.
	always_comb begin
		dec_c = 1'b0;
		mn_c  = '0;
		fm_c  = '0;
		hd_c  = '0;
		rd_c  = '0;
		rs_c  = '0;
		rx_c  = '0;
		imm_c = '0;
		case (grp)
			GRP_IDX_MEM: begin
				if (sub[2]) begin
					rd_c = bank_reg(n1, prefix_s1[6]);
					rs_c = bank_reg(n2, prefix_s1[5]);
					rx_c = rx_idx;
					if (rx_idx != 5'd0) begin
						dec_c = 1'b1;
						mn_c  = MN_MOVB + 5'(s);
						if (!sub[3]) begin
							fm_c = FORM_ST_IDX;
							hd_c = HD_ST_IDX_B + 6'(s);
						end else begin
							fm_c = FORM_LD_IDX;
							hd_c = HD_LD_IDX_B + {3'd0, s, 1'b0};
							if (prefix_s1[7] && (s != 2'd3)) begin
								mn_c = MN_MOVUB + 5'(s);
								hd_c = HD_LD_IDX_B + {3'd0, s, 1'b1};
							end
						end
					end
				end
			end
			GRP_ST_D4, GRP_LD_D4: begin
				rd_c  = bank_reg(n1, prefix_s1[6]);
				rs_c  = bank_reg(n2, prefix_s1[5]);
				rx_c  = bank_reg(sub, prefix_s1[4]);
				imm_c = {8'd0, prefix_s1[3:0], 2'b00};
				if (bank_reg(sub, prefix_s1[4]) != 5'd0) begin
					dec_c = 1'b1;
					mn_c  = MN_MOVL;
					fm_c  = (grp == GRP_ST_D4) ? FORM_ST_IDX : FORM_LD_IDX;
					hd_c  = (grp == GRP_ST_D4) ? HD_ST_IDX_L : HD_LD_IDX_L;
					if (prefix_s1[7]) begin
						imm_c = {7'd0, prefix_s1[3:0], 3'b000};
						mn_c  = MN_MOVQ;
						hd_c  = (grp == GRP_ST_D4) ? HD_ST_IDX_Q : HD_LD_IDX_Q;
					end
				end
			end
			GRP_ST_DISP: begin
				if (!(sub inside {4'h5, 4'h7, 4'h8, 4'hC, 4'hD})) begin
					rd_c  = bank_reg(n1, prefix_s1[7]);
					rs_c  = bank_reg(n2, prefix_s1[6]);
					dec_c = 1'b1;
					if (sub inside {[4'h0:4'h3]}) begin
						imm_c = 14'({8'd0, prefix_s1[5:0]} << s);
						mn_c  = MN_MOVB + 5'(s);
						fm_c  = FORM_ST_DISP;
						hd_c  = HD_ST_DISP_B + 6'(s);
					end else if ((sub == SUB_FST) || (sub == SUB_FLD)) begin
						imm_c = {6'd0, prefix_s1[5:0], 2'b00};
						mn_c  = MN_FMOVS;
						fm_c  = (sub == SUB_FST) ? FORM_ST_DISP : FORM_LD_DISP;
						hd_c  = (sub == SUB_FST) ? HD_FST_DISP : HD_FLD_DISP;
					end else begin
						imm_c = {8'd0, prefix_s1[5:0]};
						fm_c  = FORM_RIR;
						case (sub)
							SUB_AND: begin
								mn_c = MN_AND;
								hd_c = HD_AND_RIR;
							end
							SUB_XOR: begin
								mn_c = MN_XOR;
								hd_c = HD_XOR_RIR;
							end
							SUB_OR: begin
								mn_c = MN_OR;
								hd_c = HD_OR_RIR;
							end
							SUB_MUL_NEG: begin
								mn_c  = MN_MULL;
								hd_c  = HD_MUL_RIR;
								imm_c = {8'hFF, prefix_s1[5:0]};
							end
							default: begin
								mn_c = MN_MULL;
								hd_c = HD_MUL_RIR;
							end
						endcase
					end
				end
			end
			GRP_CMP_ALU: begin
				if (sub inside {SUB_CMP_EQ, SUB_CMP_HS, SUB_CMP_GE, SUB_CMP_HI,
						SUB_CMP_GT}) begin
					// Ten-bit immediate from the prefix and the second nibble.
					imm_c = {{4{prefix_s1[5]}}, prefix_s1[5:0], n2};
					rd_c  = bank_reg(n1, prefix_s1[6]);
					dec_c = 1'b1;
					fm_c  = FORM_RI;
					mn_c  = MN_CMPEQ + {1'b0, k, prefix_s1[7]};
					hd_c  = HD_CMP_EQ + {2'd0, k, prefix_s1[7]};
				end else if (sub inside {SUB_ALU_SUB, SUB_ALU_AND, SUB_ALU_ADD}) begin
					rd_c  = bank_reg(n1, prefix_s1[7]);
					rs_c  = bank_reg(n2, prefix_s1[6]);
					imm_c = {8'd0, prefix_s1[5:0]};
					dec_c = 1'b1;
					fm_c  = FORM_RIR;
					case (sub)
						SUB_ALU_SUB: begin
							mn_c = MN_SUB;
							hd_c = HD_SUB_RIR;
						end
						SUB_ALU_AND: begin
							mn_c  = MN_AND;
							hd_c  = HD_AND_RIR;
							imm_c = {8'hFF, prefix_s1[5:0]};
						end
						default: begin
							mn_c = MN_ADD;
							hd_c = HD_ADD_RIR;
						end
					endcase
				end
			end
			GRP_SHIFT: begin
				if ((sub == SUB_SHAD) || (sub == SUB_SHLD)) begin
					rd_c  = bank_reg(n1, prefix_s1[7]);
					rs_c  = bank_reg(n2, prefix_s1[6]);
					imm_c = {{8{prefix_s1[5]}}, prefix_s1[5:0]};
					dec_c = 1'b1;
					fm_c  = FORM_RIR;
					mn_c  = (sub == SUB_SHAD) ? MN_SHAD : MN_SHLD;
					hd_c  = (sub == SUB_SHAD) ? HD_SHAD : HD_SHLD;
				end
			end
			GRP_LD_DISP: begin
				if (sub != SUB_NONE) begin
					dec_c = 1'b1;
					if (sub inside {[4'h4:4'h7]}) begin
						// Indexed address computation.
						rd_c = bank_reg(n1, prefix_s1[6]);
						rs_c = bank_reg(n2, prefix_s1[5]);
						rx_c = rx_idx;
						mn_c = MN_LEAB + 5'(s);
						fm_c = FORM_LD_IDX;
						hd_c = HD_LD_IDX_B + {3'd0, s, 1'b0};
					end else begin
						rd_c  = bank_reg(n1, prefix_s1[7]);
						rs_c  = bank_reg(n2, prefix_s1[6]);
						fm_c  = FORM_LD_DISP;
						imm_c = 14'({8'd0, prefix_s1[5:0]} << s);
						if (sub inside {[4'h0:4'h3]}) begin
							mn_c = MN_MOVB + 5'(s);
							hd_c = HD_LD_DISP_B + 6'(s);
						end else if (sub inside {[4'h8:4'hB]}) begin
							mn_c = MN_LEAB + 5'(s);
							hd_c = HD_LEA_DISP;
						end else begin
							mn_c = MN_MOVUB + 5'(s);
							hd_c = HD_LDU_DISP + 6'(s);
						end
					end
				end
			end
			GRP_ADD_IMM, GRP_MOV_IMM: begin
				// Fourteen-bit immediate; prefix bit 6 set is rejected.
				imm_c = {prefix_s1[5:0], main_s1[7:0]};
				rd_c  = bank_reg(n1, prefix_s1[7]);
				if (!prefix_s1[6]) begin
					dec_c = 1'b1;
					fm_c  = FORM_RI;
					mn_c  = (grp == GRP_ADD_IMM) ? MN_ADD : MN_MOV;
					hd_c  = (grp == GRP_ADD_IMM) ? HD_ADD_RI : HD_MOV_RI;
				end
			end
			default: begin
				dec_c = 1'b0;
			end
		endcase
	end

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			decoded      <= dec_c;
			mnemonic     <= mn_c;
			operand_form <= fm_c;
			handler      <= hd_c;
			dest_reg     <= rd_c;
			src_reg      <= rs_c;
			index_reg    <= rx_c;
			immediate    <= signed'(imm_c);
		end
	end

`ifndef SYNTHESIS
	// Every request yields exactly one result, through the input and result registers.
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done)
		else $error("request did not produce a result after two cycles");

	// A result strobe always traces back to a request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a request");

	// Rejected encodings carry no operation codes.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !decoded) |-> (mnemonic == MN_MOVB && operand_form == FORM_ST_IDX &&
			handler == HD_ST_IDX_B))
		else $error("rejected encoding carries operation codes");

	// Decoded operations stay within the dense code ranges.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && decoded) |-> (handler <= HD_MAX && operand_form <= FORM_RI &&
			mnemonic <= MN_MOV))
		else $error("decoded codes out of range");

	// An indexed store is only decoded with a nonzero index register.
	a_idx_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && decoded && operand_form == FORM_ST_IDX) |-> (index_reg != 5'd0))
		else $error("indexed store decoded with zero index register");
`endif

endmodule

`default_nettype wire
